// ===== hdl/ptc_pkg.sv =====
// -----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the pressure/temperature compensation pipe.
// -----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TEMP_W   = 20;
    localparam int PRES_W   = 23;

    // temperature thresholds in 0.01 degC
    localparam int TEMP_REF  = 2000;
    localparam int TEMP_DEEP = -1500;

    // output saturation limits
    localparam int TEMP_MIN = -270000;
    localparam int TEMP_MAX = 140000;
    localparam int PRES_MIN = -4194304;
    localparam int PRES_MAX = 4194303;

    typedef enum logic [CFG_IDX_W-1:0] {
        CAL_PRES_SENS   = 3'd0,
        CAL_PRES_OFFSET = 3'd1,
        CAL_SENS_TCO    = 3'd2,
        CAL_OFF_TCO     = 3'd3,
        CAL_REF_TEMP    = 3'd4,
        CAL_TEMP_COEFF  = 3'd5
    } t_cal_idx;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    // first-order terms
    typedef struct packed {
        logic [RAW_W-1:0]   d1;
        logic signed [18:0] temp1;  // 2000 + dT*C6/2^23
        logic signed [17:0] a;      // TEMP - 2000
        logic signed [18:0] b;      // TEMP + 1500
        logic [17:0]        t2;     // dT^2/2^31
        logic signed [35:0] off1;
        logic signed [34:0] sens1;
    } t_first;

    // after second-order correction
    typedef struct packed {
        logic [RAW_W-1:0]   d1;
        logic signed [20:0] temp;
        logic signed [40:0] off;
        logic signed [39:0] sens;
    } t_comp;

endpackage

// ===== hdl/ptc_smp_if.sv =====
// -----------------------------------------------------------------------------
// ptc_smp_if
// Raw sample channel: one pressure and one temperature reading per word.
// -----------------------------------------------------------------------------
interface ptc_smp_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== hdl/ptc_res_if.sv =====
// -----------------------------------------------------------------------------
// ptc_res_if
// Result channel: compensated temperature and pressure per word.
// -----------------------------------------------------------------------------
interface ptc_res_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] temperature_centi_c;
    logic signed [22:0] pressure_centi_mbar;

    modport source (output valid, output temperature_centi_c, output pressure_centi_mbar,
                    input ready);
    modport sink   (input valid, input temperature_centi_c, input pressure_centi_mbar,
                    output ready);
endinterface

// ===== hdl/ptc_front.sv =====
// -----------------------------------------------------------------------------
// ptc_front
// Three stages: dT, the four dT products, first-order TEMP/OFF/SENS terms.
// -----------------------------------------------------------------------------
module ptc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ptc_pkg::t_cal             i_cal,
    input  logic                      i_valid,
    input  logic [ptc_pkg::RAW_W-1:0] i_d1,
    input  logic [ptc_pkg::RAW_W-1:0] i_d2,
    output logic                      o_ready,
    output logic                      o_valid,
    output ptc_pkg::t_first           o_data,
    input  logic                      i_ready
);
    import ptc_pkg::*;

    logic [2:0] r_vld;
    logic [2:0] w_en;

    logic [RAW_W-1:0]   r1_d1, r2_d1;
    logic signed [24:0] r1_dt, n_dt;
    logic signed [41:0] r2_pt, r2_po, r2_ps;
    logic signed [41:0] n_pt, n_po, n_ps;
    logic signed [49:0] r2_pdd, n_pdd;
    t_first             r3_fst, n_fst;

    logic signed [17:0] w_a;
    logic signed [35:0] w_c2, w_po;
    logic signed [34:0] w_c1, w_ps;

    // per-stage advance: a stage moves when empty or when the next one moves
    assign w_en[2] = ~r_vld[2] | i_ready;
    assign w_en[1] = ~r_vld[1] | w_en[2];
    assign w_en[0] = ~r_vld[0] | w_en[1];
    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    // stage 1: dT = D2 - C5*2^8
    assign n_dt = $signed({1'b0, i_d2}) - $signed({1'b0, i_cal.c5, 8'h00});

    // stage 2: products
    assign n_pt  = r1_dt * $signed({1'b0, i_cal.c6});
    assign n_po  = r1_dt * $signed({1'b0, i_cal.c4});
    assign n_ps  = r1_dt * $signed({1'b0, i_cal.c3});
    assign n_pdd = r1_dt * r1_dt;

    // stage 3: first-order terms, floor shifts are plain part-selects
    assign w_a  = $signed(r2_pt[40:23]);
    assign w_c2 = $signed({3'b000, i_cal.c2, 17'd0});
    assign w_po = $signed(r2_po[40:6]);
    assign w_c1 = $signed({3'b000, i_cal.c1, 16'd0});
    assign w_ps = $signed(r2_ps[40:7]);

    always_comb begin
        n_fst.d1    = r2_d1;
        n_fst.a     = w_a;
        n_fst.temp1 = 19'(w_a) + 19'(TEMP_REF);
        n_fst.b     = 19'(w_a) + 19'(TEMP_REF - TEMP_DEEP);
        n_fst.t2    = r2_pdd[48:31];
        n_fst.off1  = w_c2 + w_po;
        n_fst.sens1 = w_c1 + w_ps;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_d1 <= i_d1;
            r1_dt <= n_dt;
        end
        if (w_en[1]) begin
            r2_d1  <= r1_d1;
            r2_pt  <= n_pt;
            r2_po  <= n_po;
            r2_ps  <= n_ps;
            r2_pdd <= n_pdd;
        end
        if (w_en[2]) begin
            r3_fst <= n_fst;
        end
    end

    assign o_valid = r_vld[2];
    assign o_data  = r3_fst;

endmodule

// ===== hdl/ptc_second.sv =====
// -----------------------------------------------------------------------------
// ptc_second
// Three stages of second-order correction below 20 degC, extra below -15 degC.
// -----------------------------------------------------------------------------
module ptc_second (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ptc_pkg::t_first i_data,
    output logic            o_ready,
    output logic            o_valid,
    output ptc_pkg::t_comp  o_data,
    input  logic            i_ready
);
    import ptc_pkg::*;

    logic [2:0] r_vld;
    logic [2:0] w_en;

    // stage 1
    t_first             r1_fst;
    logic [34:0]        r1_aa, r1_bb;
    logic signed [35:0] w_aa_full;
    logic signed [37:0] w_bb_full;

    // stage 2
    logic [RAW_W-1:0]   r2_d1;
    logic signed [20:0] r2_temp, n_temp;
    logic signed [35:0] r2_off1;
    logic signed [34:0] r2_sens1;
    logic [36:0]        r2_off2a, n_off2a;
    logic [38:0]        r2_ob, n_ob;
    logic [35:0]        r2_sa, n_sa;
    logic [37:0]        r2_sb, n_sb;
    logic               w_lo_a, w_lo_b;
    logic [40:0]        w_61aa;
    logic [38:0]        w_15bb;
    logic signed [20:0] w_temp1, w_t2;

    // stage 3
    t_comp              r3_cmp, n_cmp;
    logic signed [40:0] w_off1, w_off2a, w_ob;
    logic signed [39:0] w_sens1, w_sa, w_sb;

    assign w_en[2] = ~r_vld[2] | i_ready;
    assign w_en[1] = ~r_vld[1] | w_en[2];
    assign w_en[0] = ~r_vld[0] | w_en[1];
    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    // stage 1: squares
    assign w_aa_full = i_data.a * i_data.a;
    assign w_bb_full = i_data.b * i_data.b;

    // stage 2: scaled squares, gated by the temperature bands
    assign w_lo_a = r1_fst.a[17];          // TEMP < 2000
    assign w_lo_b = r1_fst.b[18];          // TEMP < -1500
    assign w_61aa = {r1_aa, 6'd0} - {4'd0, r1_aa, 2'd0} + {6'd0, r1_aa};
    assign w_15bb = {r1_bb, 4'd0} - {4'd0, r1_bb};
    assign w_temp1 = r1_fst.temp1;
    assign w_t2    = $signed({3'b000, r1_fst.t2});

    always_comb begin
        n_off2a = w_lo_a ? w_61aa[40:4] : '0;
        n_ob    = w_lo_b ? w_15bb : '0;
        n_sa    = w_lo_a ? {r1_aa, 1'b0} : '0;
        n_sb    = w_lo_b ? {r1_bb, 3'd0} : '0;
        n_temp  = w_lo_a ? (w_temp1 - w_t2) : w_temp1;
    end

    // stage 3: OFF -= OFF2, SENS -= SENS2
    assign w_off1  = r2_off1;
    assign w_off2a = $signed({4'd0, r2_off2a});
    assign w_ob    = $signed({2'd0, r2_ob});
    assign w_sens1 = r2_sens1;
    assign w_sa    = $signed({4'd0, r2_sa});
    assign w_sb    = $signed({2'd0, r2_sb});

    always_comb begin
        n_cmp.d1   = r2_d1;
        n_cmp.temp = r2_temp;
        n_cmp.off  = w_off1 - w_off2a - w_ob;
        n_cmp.sens = w_sens1 - w_sa - w_sb;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_fst <= i_data;
            r1_aa  <= w_aa_full[34:0];
            r1_bb  <= w_bb_full[34:0];
        end
        if (w_en[1]) begin
            r2_d1    <= r1_fst.d1;
            r2_temp  <= n_temp;
            r2_off1  <= r1_fst.off1;
            r2_sens1 <= r1_fst.sens1;
            r2_off2a <= n_off2a;
            r2_ob    <= n_ob;
            r2_sa    <= n_sa;
            r2_sb    <= n_sb;
        end
        if (w_en[2]) begin
            r3_cmp <= n_cmp;
        end
    end

    assign o_valid = r_vld[2];
    assign o_data  = r3_cmp;

endmodule

// ===== hdl/ptc_pres.sv =====
// -----------------------------------------------------------------------------
// ptc_pres
// Four stages: split D1*SENS multiply, recombine, subtract OFF, scale and
// saturate both results into the output register.
// -----------------------------------------------------------------------------
module ptc_pres (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  ptc_pkg::t_comp                    i_data,
    output logic                              o_ready,
    output logic                              o_valid,
    output logic signed [ptc_pkg::TEMP_W-1:0] o_temp,
    output logic signed [ptc_pkg::PRES_W-1:0] o_pres,
    input  logic                              i_ready
);
    import ptc_pkg::*;

    logic [3:0] r_vld;
    logic [3:0] w_en;

    // stage 1: partial products on the low and high halves of SENS
    logic [43:0]        r1_plo, n_plo;
    logic signed [44:0] r1_phi, n_phi;
    logic signed [40:0] r1_off, r2_off;
    logic signed [20:0] r1_temp, r2_temp, r3_temp;

    // stage 2
    logic signed [63:0] r2_prod, n_prod, w_hi64, w_lo64;

    // stage 3
    logic signed [43:0] r3_x, n_x, w_pq, w_off;

    // stage 4
    logic signed [28:0]        w_p;
    logic signed [TEMP_W-1:0]  r4_temp, n_temp_sat;
    logic signed [PRES_W-1:0]  r4_pres, n_pres_sat;

    assign w_en[3] = ~r_vld[3] | i_ready;
    assign w_en[2] = ~r_vld[2] | w_en[3];
    assign w_en[1] = ~r_vld[1] | w_en[2];
    assign w_en[0] = ~r_vld[0] | w_en[1];
    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
        end
    end

    assign n_plo = i_data.d1 * i_data.sens[19:0];
    assign n_phi = $signed({1'b0, i_data.d1}) * $signed(i_data.sens[39:20]);

    // D1*SENS = hi*2^20 + lo
    assign w_hi64 = r1_phi;
    assign w_lo64 = $signed({20'd0, r1_plo});
    assign n_prod = (w_hi64 <<< 20) + w_lo64;

    // D1*SENS/2^21 - OFF
    assign w_pq  = $signed(r2_prod[63:21]);
    assign w_off = r2_off;
    assign n_x   = w_pq - w_off;

    // /2^15, then saturate
    assign w_p = $signed(r3_x[43:15]);

    always_comb begin
        if (w_p < PRES_MIN) begin
            n_pres_sat = PRES_W'(PRES_MIN);
        end else if (w_p > PRES_MAX) begin
            n_pres_sat = PRES_W'(PRES_MAX);
        end else begin
            n_pres_sat = w_p[PRES_W-1:0];
        end
        if (r3_temp < TEMP_MIN) begin
            n_temp_sat = TEMP_W'(TEMP_MIN);
        end else if (r3_temp > TEMP_MAX) begin
            n_temp_sat = TEMP_W'(TEMP_MAX);
        end else begin
            n_temp_sat = r3_temp[TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_plo  <= n_plo;
            r1_phi  <= n_phi;
            r1_off  <= i_data.off;
            r1_temp <= i_data.temp;
        end
        if (w_en[1]) begin
            r2_prod <= n_prod;
            r2_off  <= r1_off;
            r2_temp <= r1_temp;
        end
        if (w_en[2]) begin
            r3_x    <= n_x;
            r3_temp <= r2_temp;
        end
        if (w_en[3]) begin
            r4_temp <= n_temp_sat;
            r4_pres <= n_pres_sat;
        end
    end

    assign o_valid = r_vld[3];
    assign o_temp  = r4_temp;
    assign o_pres  = r4_pres;

endmodule

// ===== hdl/pressure_temperature_compensation_unit.sv =====
// -----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Second-order compensated temperature and pressure from raw sensor readings.
// -----------------------------------------------------------------------------
// Usage:
//   i_smp  : sample words, raw 24-bit pressure (D1) and temperature (D2).
//   o_res  : result words, temperature in 0.01 degC and pressure in 0.01 mbar,
//            both saturated to their output ranges.
//   i_cfg_*: write port for the six calibration words C1..C6 (index 0..5);
//            other indexes are dropped. Write only while the pipe is empty.
// Timing:
//   Ten register stages from accept to result: dT and its four products,
//   first-order terms, squares and second-order terms, a two-part 24x40
//   multiply for D1*SENS, offset subtract, then scale and saturate into the
//   output register. One word per cycle is taken unless a stall backs up to the input.
// Flow control:
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles close up and words are taken while a result waits on o_res.
//   A stall holds each word that has no empty stage ahead of it; nothing is dropped or repeated.
// Reset:
//   Synchronous, active low. Clears all valid bits and the calibration words.
// -----------------------------------------------------------------------------
module pressure_temperature_compensation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ptc_pkg::CAL_W-1:0]     i_cfg_data,
    ptc_smp_if.sink                       i_smp,
    ptc_res_if.source                     o_res
);
    import ptc_pkg::*;

    t_cal   r_cal;
    logic   w_fr_valid, w_fr_ready;
    t_first w_fr_data;
    logic   w_sc_valid, w_sc_ready;
    t_comp  w_sc_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (t_cal_idx'(i_cfg_idx))
                CAL_PRES_SENS:   r_cal.c1 <= i_cfg_data;
                CAL_PRES_OFFSET: r_cal.c2 <= i_cfg_data;
                CAL_SENS_TCO:    r_cal.c3 <= i_cfg_data;
                CAL_OFF_TCO:     r_cal.c4 <= i_cfg_data;
                CAL_REF_TEMP:    r_cal.c5 <= i_cfg_data;
                CAL_TEMP_COEFF:  r_cal.c6 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (r_cal),
        .i_valid (i_smp.valid),
        .i_d1    (i_smp.raw_pressure),
        .i_d2    (i_smp.raw_temperature),
        .o_ready (i_smp.ready),
        .o_valid (w_fr_valid),
        .o_data  (w_fr_data),
        .i_ready (w_fr_ready)
    );

    ptc_second u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .i_data  (w_fr_data),
        .o_ready (w_fr_ready),
        .o_valid (w_sc_valid),
        .o_data  (w_sc_data),
        .i_ready (w_sc_ready)
    );

    ptc_pres u_pres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sc_valid),
        .i_data  (w_sc_data),
        .o_ready (w_sc_ready),
        .o_valid (o_res.valid),
        .o_temp  (o_res.temperature_centi_c),
        .o_pres  (o_res.pressure_centi_mbar),
        .i_ready (o_res.ready)
    );

endmodule

// ===== bench/ptc_result_checker.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// ptc_result_checker
// Watches the sample, result and calibration ports of the compensation unit,
// works out the compensated temperature and pressure of each accepted sample
// word and compares them, in order, with the result words that come out.
// -----------------------------------------------------------------------------
module ptc_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ptc_pkg::CAL_W-1:0]     i_cfg_data,
    ptc_smp_if                            i_smp,
    ptc_res_if                            i_res,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ptc_pkg::*;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [PRES_W-1:0] pres;
    } t_reading;

    logic [CAL_W-1:0] cal_words [0:5];
    t_reading         reading_q [$];
    int               fail_count = 0;
    int               pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    initial begin
        for (int i = 0; i < 6; i++) cal_words[i] = '0;
    end

    // Second-order compensation in 64-bit signed math; >>> on longint floors.
    function automatic t_reading compensate(input logic [RAW_W-1:0] d1_raw,
                                            input logic [RAW_W-1:0] d2_raw);
        longint   d1, d2, c1, c2, c3, c4, c5, c6;
        longint   dt, temp, off, sens, t2, a, b, off2, sens2, pres;
        t_reading r;
        d1 = d1_raw;
        d2 = d2_raw;
        c1 = cal_words[CAL_PRES_SENS];
        c2 = cal_words[CAL_PRES_OFFSET];
        c3 = cal_words[CAL_SENS_TCO];
        c4 = cal_words[CAL_OFF_TCO];
        c5 = cal_words[CAL_REF_TEMP];
        c6 = cal_words[CAL_TEMP_COEFF];

        dt   = d2 - c5 * 256;
        temp = TEMP_REF + ((dt * c6) >>> 23);
        off  = c2 * 131072 + ((c4 * dt) >>> 6);
        sens = c1 * 65536 + ((c3 * dt) >>> 7);

        if (temp < TEMP_REF) begin
            t2    = (dt * dt) >>> 31;
            a     = temp - TEMP_REF;
            off2  = (61 * (a * a)) >>> 4;
            sens2 = 2 * (a * a);
            if (temp < TEMP_DEEP) begin
                b     = temp - TEMP_DEEP;
                off2  = off2 + 15 * (b * b);
                sens2 = sens2 + 8 * (b * b);
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
        end

        pres = (((d1 * sens) >>> 21) - off) >>> 15;

        if (temp < TEMP_MIN) temp = TEMP_MIN;
        if (temp > TEMP_MAX) temp = TEMP_MAX;
        if (pres < PRES_MIN) pres = PRES_MIN;
        if (pres > PRES_MAX) pres = PRES_MAX;

        r.temp = temp[TEMP_W-1:0];
        r.pres = pres[PRES_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) cal_words[i] = '0;
            reading_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (reading_q.size() == 0) begin
                    $display("%0t: result word with nothing expected: temp %0d pres %0d",
                             $time, i_res.temperature_centi_c, i_res.pressure_centi_mbar);
                    fail_count++;
                end else begin
                    want = reading_q.pop_front();
                    if (i_res.temperature_centi_c !== want.temp) begin
                        $display("%0t: temperature mismatch: expected %0d actual %0d",
                                 $time, want.temp, i_res.temperature_centi_c);
                        fail_count++;
                    end
                    if (i_res.pressure_centi_mbar !== want.pres) begin
                        $display("%0t: pressure mismatch: expected %0d actual %0d",
                                 $time, want.pres, i_res.pressure_centi_mbar);
                        fail_count++;
                    end
                end
            end
            if (i_smp.valid && i_smp.ready)
                reading_q.push_back(compensate(i_smp.raw_pressure, i_smp.raw_temperature));
            // indexes past the last calibration word are dropped
            if (i_cfg_we && i_cfg_idx <= CAL_TEMP_COEFF)
                cal_words[i_cfg_idx] = i_cfg_data;
        end
        pending = reading_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// Drives the compensation unit with directed and random sample words under
// several calibration sets, with random gaps on the sample side and random
// stalls on the result side; the checker beside the unit scores every result.
// -----------------------------------------------------------------------------
module tb_top;
    import ptc_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CAL_W-1:0]     cfg_data = '0;
    logic [CAL_W-1:0]     cur_ref_temp = '0;
    bit                   quiet = 1'b0;
    int                   stall_left = 0;
    int                   fail_count;
    int                   pending;

    ptc_smp_if smp_ch ();
    ptc_res_if res_ch ();

    pressure_temperature_compensation_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_ch),
        .o_res      (res_ch)
    );

    ptc_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_smp        (smp_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        smp_ch.valid           = 1'b0;
        smp_ch.raw_pressure    = '0;
        smp_ch.raw_temperature = '0;
        res_ch.ready           = 1'b0;
    end

    // result side stalls in bursts
    always @(negedge clk) begin
        if (stall_left == 0 && !quiet && $urandom_range(0, 6) == 0)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic load_cal(input logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6);
        write_reg(CAL_PRES_SENS, c1);
        write_reg(CAL_PRES_OFFSET, c2);
        write_reg(CAL_SENS_TCO, c3);
        write_reg(CAL_OFF_TCO, c4);
        write_reg(CAL_REF_TEMP, c5);
        write_reg(CAL_TEMP_COEFF, c6);
        // one write past the last word, which must not land anywhere
        write_reg(CFG_IDX_W'(CAL_TEMP_COEFF + 1 + $urandom_range(0, 1)), CAL_W'($urandom));
        cfg_we <= 1'b0;
        cur_ref_temp = c5;
    endtask

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        smp_ch.valid           <= 1'b1;
        smp_ch.raw_pressure    <= d1;
        smp_ch.raw_temperature <= d2;
        @(posedge clk);
        while (!smp_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        smp_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [CAL_W-1:0] rand_cal_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CAL_W'($urandom);
        endcase
    endfunction

    // mostly close to the reference point so both cold branches get hit
    function automatic logic [RAW_W-1:0] rand_raw_temp();
        longint v;
        longint ofs;
        int     sh;
        if ($urandom_range(0, 4) == 0) return RAW_W'($urandom);
        sh  = $urandom_range(0, 23);
        ofs = $urandom_range(0, 1 << sh);
        if ($urandom_range(0, 1) == 1) ofs = -ofs;
        v = longint'(cur_ref_temp) * 256 + ofs;
        if (v < 0) v = 0;
        if (v > 24'hFFFFFF) v = 24'hFFFFFF;
        return v[RAW_W-1:0];
    endfunction

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // uncalibrated: all words still zero
        send_reading(24'd0, 24'd0);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'h800000, 24'h123456);
        drain_results();

        // typical part; C5*256 = 8077568 is exactly 20.00 degC
        load_cal(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
        send_reading(24'd6465444, 24'd8077568);
        send_reading(24'd6465444, 24'd8077567);
        send_reading(24'd6465444, 24'd8569150);
        send_reading(24'd0, 24'd7481896);
        send_reading(24'hFFFFFF, 24'd7481896);
        send_reading(24'd6465444, 24'd7035143);   // exactly -15.00 degC
        send_reading(24'd6465444, 24'd7035142);   // one raw count below it, still -15.00 degC
        send_reading(24'd6465444, 24'd0);
        send_reading(24'd6465444, 24'hFFFFFF);
        send_reading(24'hFFFFFF, 24'd0);
        send_reading(24'd0, 24'hFFFFFF);
        drain_results();

        load_cal('1, '1, '1, '1, '1, '1);
        send_reading(24'd0, 24'd0);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'hFFFFFF, 24'd0);
        send_reading(24'd0, 24'hFFFFFF);
        drain_results();

        load_cal('1, '0, '1, '0, '1, '1);
        send_reading(24'hFFFFFF, 24'd0);
        send_reading(24'h5A5A5A, 24'd1);
        drain_results();

        for (int ph = 0; ph < 12; ph++) begin
            quiet = (ph == 5 || ph == 11);
            load_cal(rand_cal_word(), rand_cal_word(), rand_cal_word(),
                     rand_cal_word(), rand_cal_word(), rand_cal_word());
            repeat (100) send_reading(RAW_W'($urandom), rand_raw_temp());
            drain_results();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ptc_pkg.sv
hdl/ptc_smp_if.sv
hdl/ptc_res_if.sv
hdl/ptc_front.sv
hdl/ptc_second.sv
hdl/ptc_pres.sv
hdl/pressure_temperature_compensation_unit.sv
bench/ptc_result_checker.sv
bench/tb_top.sv
